// File: rtl/mrb_pkg.sv
// Modal resonator bank: shared constants, codes and the job type passed
// from the front end through the queue to the sweep engine.
// No dependencies.
package mrb_pkg;

  localparam int MAX_MODES   = 2048;
  localparam int MODE_W      = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam int CNT_W       = $clog2(MAX_MODES + 1);

  localparam int IDX_W       = 11;
  localparam int SEL_W       = 2;
  localparam int COEF_W      = 32;
  localparam int CFG_MODES_W = 12;
  localparam int GAIN_W      = 24;
  localparam int SAMPLE_W    = 24;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  localparam int FRAC_W      = 28;
  localparam int PROD_W      = 2 * COEF_W;
  localparam int ACC_W       = PROD_W + MODE_W + 1;
  localparam int SUM_W       = 40;
  localparam int SCALE_W     = SUM_W + GAIN_W + 1;
  localparam int OUT_SHIFT   = 5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_MODES_W-1:0] ACTIVE_MODES_RST = CFG_MODES_W'(2041);
  localparam logic [GAIN_W-1:0]      OUTPUT_GAIN_RST  = GAIN_W'(1000000);

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_MODES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN  = CFG_IDX_W'(1);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [SEL_W-1:0] {
    COEF_C1,
    COEF_C2,
    COEF_C3,
    COEF_WEIGHT
  } coef_sel_t;

  typedef struct packed {
    logic              is_tick;
    logic              excite;
    logic [MODE_W-1:0] addr;
    coef_sel_t         coef_select;
    logic [COEF_W-1:0] coef_value;
  } job_t;

endpackage

// File: rtl/mrb_if.sv
// Modal resonator bank: valid/ready channel interfaces for input items and
// result samples. Depends on mrb_pkg.
interface mrb_in_if;
  import mrb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [IDX_W-1:0]         mode_index;
  logic [SEL_W-1:0]         coef_select;
  logic signed [COEF_W-1:0] coef_value;
  logic                     armed;
  logic                     mute_switch;

  modport source (
    output valid, mode, mode_index, coef_select, coef_value, armed, mute_switch,
    input  ready
  );
  modport sink (
    input  valid, mode, mode_index, coef_select, coef_value, armed, mute_switch,
    output ready
  );
endinterface

interface mrb_out_if;
  import mrb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (
    output valid, sample_out,
    input  ready
  );
  modport sink (
    input  valid, sample_out,
    output ready
  );
endinterface

// File: rtl/modal_resonator_bank_top.sv
// Modal resonator bank top level: configuration registers, front end, job
// queue and sweep engine. Depends on mrb_pkg, mrb_if, mrb_front, mrb_queue, mrb_back.
//
//   channel  | direction | beat carries
//   ---------+-----------+----------------------------------------------------
//   in_ch    | in        | mode, mode_index, coef_select, coef_value, armed, mute
//   out_ch   | out       | sample_out
//   cfg_*    | in        | write enable, register index, data (no back-pressure)
//
// A load is written straight into the coefficient memories by the sweep engine;
// an armed tick sweeps the effective mode count through the single shared
// multiply-accumulate pipeline, paced by the one read port of the mode-state
// memory, and skips the sweep when no mode is active.
// After reset all MAX_MODES (2048) entries of the mode-state memory are cleared
// with in_ch.ready low. The job queue keeps taking beats until it is full while a
// finished sample waits on out_ch; an unarmed tick is dropped without a result.
module modal_resonator_bank_top (
  input  logic                              clk,
  input  logic                              rst_n,
  mrb_in_if.sink                            in_ch,
  mrb_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [mrb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mrb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import mrb_pkg::*;

  logic [CFG_MODES_W-1:0] active_modes_r;
  logic [GAIN_W-1:0]      output_gain_r;
  logic                   clearing;
  logic                   push_valid;
  logic                   push_ready;
  job_t                   push_data;
  logic                   job_valid;
  logic                   job_ready;
  job_t                   job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_modes_r <= ACTIVE_MODES_RST;
      output_gain_r  <= OUTPUT_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTIVE_MODES: active_modes_r <= cfg_wdata[CFG_MODES_W-1:0];
        CFG_OUTPUT_GAIN:  output_gain_r  <= cfg_wdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mrb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .clearing  (clearing),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  mrb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (job_valid),
    .pop_ready (job_ready),
    .pop_data  (job)
  );

  mrb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .active_modes(active_modes_r),
    .output_gain (output_gain_r),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job),
    .clearing    (clearing),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .res_sample  (out_ch.sample_out)
  );

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) clearing |-> !in_ch.ready
  ) else $error("input beat offered ready during state clearing");

  a_clear_after_reset: assert property (
    @(posedge clk) !rst_n |=> clearing
  ) else $error("state clearing did not start after reset");

  a_no_result_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) clearing |-> !out_ch.valid
  ) else $error("result presented during state clearing");
`endif

endmodule

// File: rtl/mrb_ram.sv
// Modal resonator bank: generic single-write, single-read RAM with a
// registered read port. No dependencies.
module mrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/mrb_front.sv
// Modal resonator bank front end: accepts input beats, drops unarmed ticks
// and out-of-range loads, resolves excitation. Depends on mrb_pkg, mrb_if.
module mrb_front (
  input  logic          clk,
  input  logic          rst_n,
  mrb_in_if.sink        in_ch,
  input  logic          clearing,
  output logic          push_valid,
  input  logic          push_ready,
  output mrb_pkg::job_t push_data
);
  import mrb_pkg::*;

  logic first_r;
  logic mute_prev_r;
  logic accept;
  logic is_tick;
  logic idx_ok;
  logic tick_take;

  assign in_ch.ready = push_ready && !clearing;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_tick     = (in_ch.mode == MODE_TICK);
  assign idx_ok      = (32'(in_ch.mode_index) < 32'(MAX_MODES));
  assign tick_take   = accept && is_tick && in_ch.armed;

  assign push_valid = accept && (is_tick ? in_ch.armed : idx_ok);

  always_comb begin
    push_data.is_tick     = is_tick;
    push_data.excite      = first_r || (in_ch.mute_switch && !mute_prev_r);
    push_data.addr        = MODE_W'(in_ch.mode_index);
    push_data.coef_select = coef_sel_t'(in_ch.coef_select);
    push_data.coef_value  = in_ch.coef_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= 1'b1;
      mute_prev_r <= 1'b0;
    end else if (tick_take) begin
      first_r     <= 1'b0;
      mute_prev_r <= in_ch.mute_switch;
    end
  end

endmodule

// File: rtl/mrb_queue.sv
// Modal resonator bank: short job queue between front end and sweep engine.
// Depends on mrb_pkg.
module mrb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  mrb_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mrb_pkg::job_t pop_data
);
  import mrb_pkg::*;

  job_t              ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;
  logic              pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = ent_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/mrb_back.sv
// Modal resonator bank sweep engine: coefficient and mode-state memories,
// pipelined multiply-accumulate over active modes, gain and saturation.
// Depends on mrb_pkg, mrb_ram.
module mrb_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mrb_pkg::CFG_MODES_W-1:0]     active_modes,
  input  logic [mrb_pkg::GAIN_W-1:0]          output_gain,
  input  logic                                job_valid,
  output logic                                job_ready,
  input  mrb_pkg::job_t                       job,
  output logic                                clearing,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mrb_pkg::SAMPLE_W-1:0] res_sample
);
  import mrb_pkg::*;

  localparam int TOT_W = PROD_W + 2;
  localparam int RND_W = TOT_W - FRAC_W;
  localparam int ARN_W = ACC_W - FRAC_W;
  localparam int EMT_W = SCALE_W - OUT_SHIFT;
  localparam logic signed [63:0] StateMax  = 64'sd2147483647;
  localparam logic signed [63:0] StateMin  = -64'sd2147483648;
  localparam logic signed [63:0] SumMax    = 64'sd1 <<< 38;
  localparam logic signed [63:0] SumMin    = -(64'sd1 <<< 38);
  localparam logic signed [63:0] SampleMax = 64'sd8388607;
  localparam logic signed [63:0] SampleMin = -64'sd8388608;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_ROUND,
    S_SCALE,
    S_EMIT
  } state_t;

  state_t            state_r;
  logic [MODE_W-1:0] clr_addr_r;
  logic [MODE_W-1:0] m_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              excite_r;
  logic              s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic              out_valid_r;
  logic [CNT_W-1:0]  eff_cnt;
  logic              tick_start;
  logic              issue;
  logic              last_issue;
  logic              clear_last;
  logic              slot_free;

  logic [MODE_W-1:0] a1_r, a2_r, a3_r;
  logic [COEF_W-1:0] coef_rd [4];
  logic [2*COEF_W-1:0] st_rd;
  logic                st_we;
  logic [MODE_W-1:0]   st_waddr;
  logic [2*COEF_W-1:0] st_wdata;

  logic signed [PROD_W-1:0]   p1_r, p2_r, pw_r;
  logic signed [COEF_W-1:0]   c3_r, w2_r, x2_r, w3_r, x3_r, nxt_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SCALE_W-1:0]  scaled_r;
  logic signed [SAMPLE_W-1:0] res_sample_r;

  logic [TOT_W-1:0]          tot;
  logic signed [63:0]        rnd64;
  logic signed [COEF_W-1:0]  nxt_c;
  logic [ACC_W-1:0]          acc_h;
  logic signed [63:0]        arn64;
  logic signed [SUM_W-1:0]   sum_c;
  logic [SCALE_W-1:0]        emt_t;
  logic signed [63:0]        emt64;
  logic signed [SAMPLE_W-1:0] sample_c;

  assign clearing   = (state_r == S_CLEAR);
  assign job_ready  = (state_r == S_IDLE);
  assign tick_start = job_ready && job_valid && job.is_tick;
  assign issue      = (state_r == S_SWEEP);
  assign last_issue = (CNT_W'(m_r) == cnt_r - CNT_W'(1));
  assign clear_last = (clr_addr_r == MODE_W'(MAX_MODES - 1));
  assign slot_free  = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign res_sample = res_sample_r;

  always_comb begin
    if (32'(active_modes) > 32'(MAX_MODES)) begin
      eff_cnt = CNT_W'(MAX_MODES);
    end else begin
      eff_cnt = CNT_W'(active_modes);
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_coef
    mrb_ram #(
      .WIDTH(COEF_W),
      .DEPTH(MAX_MODES)
    ) u_coef_ram (
      .clk  (clk),
      .we   (job_ready && job_valid && !job.is_tick && (job.coef_select == coef_sel_t'(k))),
      .waddr(job.addr),
      .wdata(job.coef_value),
      .re   (issue),
      .raddr(m_r),
      .rdata(coef_rd[k])
    );
  end

  assign st_we    = clearing || s3_v_r;
  assign st_waddr = clearing ? clr_addr_r : a3_r;
  assign st_wdata = clearing ? '0 : {nxt_r, x3_r};

  mrb_ram #(
    .WIDTH(2 * COEF_W),
    .DEPTH(MAX_MODES)
  ) u_state_ram (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .re   (issue),
    .raddr(m_r),
    .rdata(st_rd)
  );

  always_comb begin
    tot = TOT_W'(p1_r) + TOT_W'(p2_r) + (TOT_W'(1) << (FRAC_W - 1));
    if (excite_r) begin
      tot = tot + {{(TOT_W - COEF_W - FRAC_W){c3_r[COEF_W-1]}}, c3_r, {FRAC_W{1'b0}}};
    end
    rnd64 = 64'($signed(tot[TOT_W-1:FRAC_W]));
    if (rnd64 > StateMax) begin
      nxt_c = COEF_W'(StateMax);
    end else if (rnd64 < StateMin) begin
      nxt_c = COEF_W'(StateMin);
    end else begin
      nxt_c = COEF_W'(rnd64);
    end
  end

  always_comb begin
    acc_h = acc_r + (ACC_W'(1) << (FRAC_W - 1));
    arn64 = 64'($signed(acc_h[ACC_W-1:FRAC_W]));
    if (arn64 > SumMax) begin
      sum_c = SUM_W'(SumMax);
    end else if (arn64 < SumMin) begin
      sum_c = SUM_W'(SumMin);
    end else begin
      sum_c = SUM_W'(arn64);
    end
  end

  always_comb begin
    emt_t = scaled_r + SCALE_W'(1 << (OUT_SHIFT - 1));
    emt64 = 64'($signed(emt_t[SCALE_W-1:OUT_SHIFT]));
    if (emt64 > SampleMax) begin
      sample_c = SAMPLE_W'(SampleMax);
    end else if (emt64 < SampleMin) begin
      sample_c = SAMPLE_W'(SampleMin);
    end else begin
      sample_c = SAMPLE_W'(emt64);
    end
  end

  always_ff @(posedge clk) begin
    a1_r  <= m_r;
    a2_r  <= a1_r;
    a3_r  <= a2_r;
    p1_r  <= PROD_W'($signed(coef_rd[COEF_C1])) * PROD_W'($signed(st_rd[2*COEF_W-1:COEF_W]));
    p2_r  <= PROD_W'($signed(coef_rd[COEF_C2])) * PROD_W'($signed(st_rd[COEF_W-1:0]));
    c3_r  <= $signed(coef_rd[COEF_C3]);
    w2_r  <= $signed(coef_rd[COEF_WEIGHT]);
    x2_r  <= $signed(st_rd[2*COEF_W-1:COEF_W]);
    nxt_r <= nxt_c;
    w3_r  <= w2_r;
    x3_r  <= x2_r;
    pw_r  <= PROD_W'(nxt_r) * PROD_W'(w3_r);
    if (tick_start) begin
      acc_r <= '0;
    end else if (s4_v_r) begin
      acc_r <= acc_r + ACC_W'(pw_r);
    end
    sum_r    <= sum_c;
    scaled_r <= SCALE_W'(sum_r) * SCALE_W'($signed({1'b0, output_gain}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      m_r         <= '0;
      cnt_r       <= '0;
      excite_r    <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      if (state_r == S_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + MODE_W'(1);
          if (clear_last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (tick_start) begin
            m_r      <= '0;
            cnt_r    <= eff_cnt;
            excite_r <= job.excite;
            state_r  <= (eff_cnt == '0) ? S_ROUND : S_SWEEP;
          end
        end
        S_SWEEP: begin
          m_r <= m_r + MODE_W'(1);
          if (last_issue) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!(s1_v_r || s2_v_r || s3_v_r || s4_v_r)) begin
            state_r <= S_ROUND;
          end
        end
        S_ROUND: state_r <= S_SCALE;
        S_SCALE: state_r <= S_EMIT;
        S_EMIT: begin
          if (slot_free) begin
            res_sample_r <= sample_c;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

endmodule
